@@ rtl/core/ctu_pkg.sv @@
// Package for the cascading timer unit: request/response types, codes, widths.
// Used by cascading_timer_unit. No dependencies.
package ctu_pkg;

    localparam int NUM_TIMERS = 4;
    localparam int TMR_W      = $clog2(NUM_TIMERS);
    localparam int MASK_W     = 4;
    localparam int COUNT_W    = 28;
    localparam int SUM_W      = COUNT_W + 1;
    localparam int RELOAD_W   = 17;
    localparam int SHIFT_W    = 4;
    localparam int VALUE_W    = 16;
    localparam int CTL_W      = 8;

    localparam logic [1:0] KIND_ADVANCE = 2'd0;
    localparam logic [1:0] KIND_CONTROL = 2'd1;
    localparam logic [1:0] KIND_RELOAD  = 2'd2;
    localparam logic [1:0] KIND_READ    = 2'd3;

    localparam logic [1:0] MODE_INACTIVE = 2'd0;
    localparam logic [1:0] MODE_PRESCALE = 2'd1;
    localparam logic [1:0] MODE_CASCADE  = 2'd2;

    localparam int CTL_ENABLE  = 7;
    localparam int CTL_IRQ     = 6;
    localparam int CTL_CASCADE = 2;

    localparam logic [RELOAD_W-1:0] RELOAD_RESET = 17'h10000;
    localparam logic [COUNT_W-1:0]  COUNT_MIN    = {1'b1, {(COUNT_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         timer_index;
        logic [VALUE_W-1:0] data_value;
        logic [VALUE_W-1:0] elapsed_cycles;
    } req_t;

    typedef struct packed {
        logic [MASK_W-1:0]  overflow_mask;
        logic [MASK_W-1:0]  irq_flags;
        logic [VALUE_W-1:0] counter_value;
    } rsp_t;

    function automatic logic [SHIFT_W-1:0] prescale_shift(input logic [1:0] sel);
        logic [SHIFT_W-1:0] sh;
        case (sel)
            2'd0:    sh = 4'd0;
            2'd1:    sh = 4'd6;
            2'd2:    sh = 4'd8;
            default: sh = 4'd10;
        endcase
        return sh;
    endfunction

endpackage

@@ rtl/core/cascading_timer_unit.sv @@
// Cascading prescaled timer unit, four timers sharing one 29-bit adder.
// Depends on ctu_pkg.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------
//  request | req_valid | req_stall | req (req_t)
//  result  | rsp_valid | rsp_stall | rsp (rsp_t)
//
// Advance: an accept step, then three adder passes per timer (subtract, reload,
// visible), then a load of the result register. Writes and reads go from accept
// straight to that load. No new request is taken before it. Reset clears timer
// state, with each reload at 17'h10000. A waiting result holds only the final load step.
module cascading_timer_unit
    import ctu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUB  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_VIS  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;
    localparam logic [TMR_W-1:0] LAST_TMR = TMR_W'(NUM_TIMERS - 1);

    logic [2:0]                state_reg;
    logic [TMR_W-1:0]          tmr_reg;
    logic [VALUE_W-1:0]        cyc_reg;
    logic                      carry_reg;
    rsp_t                      res_reg;
    rsp_t                      rsp_reg;
    logic                      rsp_valid_reg;

    logic [1:0]                mode_reg   [NUM_TIMERS];
    logic [COUNT_W-1:0]        count_reg  [NUM_TIMERS];
    logic [RELOAD_W-1:0]       reload_reg [NUM_TIMERS];
    logic [SHIFT_W-1:0]        shift_reg  [NUM_TIMERS];
    logic                      irqen_reg  [NUM_TIMERS];
    logic                      pend_reg   [NUM_TIMERS];
    logic [CTL_W-1:0]          pctl_reg   [NUM_TIMERS];
    logic [VALUE_W-1:0]        vis_reg    [NUM_TIMERS];

    logic [1:0]                cur_mode;
    logic [COUNT_W-1:0]        cur_count;
    logic [RELOAD_W-1:0]       cur_reload;
    logic [SHIFT_W-1:0]        cur_shift;
    logic [CTL_W-1:0]          cur_ctl;
    logic [SUM_W-1:0]          count_sext;
    logic [SUM_W-1:0]          count_shr;
    logic [SUM_W-1:0]          reload_scaled;
    logic [SUM_W-1:0]          op_a;
    logic [SUM_W-1:0]          op_b;
    logic                      op_sub;
    logic [SUM_W-1:0]          sum;
    logic [COUNT_W-1:0]        floored;
    logic                      active;
    logic                      hit;
    logic [MASK_W-1:0]         tmr_bit;
    logic [SHIFT_W-1:0]        start_shift;
    logic [SUM_W-1:0]          start_scaled;
    logic [VALUE_W-1:0]        start_vis;
    logic                      req_take;
    logic                      rsp_load;

    assign cur_mode   = mode_reg[tmr_reg];
    assign cur_count  = count_reg[tmr_reg];
    assign cur_reload = reload_reg[tmr_reg];
    assign cur_shift  = shift_reg[tmr_reg];
    assign cur_ctl    = pctl_reg[tmr_reg];

    assign active        = (cur_mode != MODE_INACTIVE);
    assign hit           = active && (cur_count[COUNT_W-1] || (cur_count == '0));
    assign tmr_bit       = MASK_W'(1) << tmr_reg;
    assign count_sext    = {cur_count[COUNT_W-1], cur_count};
    assign count_shr     = SUM_W'($signed(count_sext) >>> cur_shift);
    assign reload_scaled = {{(SUM_W-RELOAD_W){1'b0}}, cur_reload} << cur_shift;

    assign start_shift  = cur_ctl[CTL_CASCADE] ? '0 : prescale_shift(cur_ctl[1:0]);
    assign start_scaled = {{(SUM_W-RELOAD_W){1'b0}}, cur_reload} << start_shift;
    assign start_vis    = VALUE_W'(~cur_reload[VALUE_W-1:0] + VALUE_W'(1));

    // shared adder: a + b, or a - b through carry-in
    always_comb
    begin
        op_a   = '0;
        op_b   = count_shr;
        op_sub = 1'b1;
        case (state_reg)
            ST_SUB:
            begin
                op_a = count_sext;
                op_b = (cur_mode == MODE_CASCADE) ? {{(SUM_W-1){1'b0}}, carry_reg}
                                                  : {{(SUM_W-VALUE_W){1'b0}}, cyc_reg};
            end
            ST_ADD:
            begin
                op_a   = count_sext;
                op_b   = reload_scaled;
                op_sub = 1'b0;
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    assign sum     = op_a + (op_sub ? ~op_b : op_b) + {{(SUM_W-1){1'b0}}, op_sub};
    assign floored = (sum[SUM_W-1] && !sum[SUM_W-2]) ? COUNT_MIN : sum[COUNT_W-1:0];

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign rsp_load  = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tmr_reg       <= '0;
            cyc_reg       <= '0;
            carry_reg     <= 1'b0;
            res_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                mode_reg[i]   <= MODE_INACTIVE;
                count_reg[i]  <= '0;
                reload_reg[i] <= RELOAD_RESET;
                shift_reg[i]  <= '0;
                irqen_reg[i]  <= 1'b0;
                pend_reg[i]   <= 1'b0;
                pctl_reg[i]   <= '0;
                vis_reg[i]    <= '0;
            end
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_reg       <= res_reg;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_take)
                    begin
                        tmr_reg   <= '0;
                        carry_reg <= 1'b0;
                        cyc_reg   <= req.elapsed_cycles;
                        state_reg <= (req.kind == KIND_ADVANCE) ? ST_SUB : ST_DONE;
                        unique case (req.kind)
                            KIND_ADVANCE:
                                res_reg <= '0;
                            KIND_CONTROL:
                            begin
                                res_reg                   <= '0;
                                pctl_reg[req.timer_index] <= req.data_value[CTL_W-1:0];
                                pend_reg[req.timer_index] <= 1'b1;
                            end
                            KIND_RELOAD:
                            begin
                                res_reg <= '0;
                                reload_reg[req.timer_index] <=
                                    RELOAD_RESET - {1'b0, req.data_value};
                            end
                            default:
                                res_reg <= '{overflow_mask: '0,
                                             irq_flags:     '0,
                                             counter_value: vis_reg[req.timer_index]};
                        endcase
                    end
                end
                ST_SUB:
                begin
                    if (active)
                        count_reg[tmr_reg] <= floored;
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    carry_reg <= hit;
                    if (hit)
                    begin
                        count_reg[tmr_reg] <= sum[COUNT_W-1:0];
                        res_reg <= '{overflow_mask: res_reg.overflow_mask | tmr_bit,
                                     irq_flags:     res_reg.irq_flags |
                                                    (tmr_bit & {MASK_W{irqen_reg[tmr_reg]}}),
                                     counter_value: res_reg.counter_value};
                    end
                    state_reg <= ST_VIS;
                end
                ST_VIS:
                begin
                    if (active)
                        vis_reg[tmr_reg] <= sum[VALUE_W-1:0];
                    if (pend_reg[tmr_reg])
                    begin
                        pend_reg[tmr_reg] <= 1'b0;
                        if (!cur_ctl[CTL_ENABLE])
                            mode_reg[tmr_reg] <= MODE_INACTIVE;
                        else if (!active)
                        begin
                            mode_reg[tmr_reg]  <= cur_ctl[CTL_CASCADE] ? MODE_CASCADE
                                                                       : MODE_PRESCALE;
                            shift_reg[tmr_reg] <= start_shift;
                            irqen_reg[tmr_reg] <= cur_ctl[CTL_IRQ];
                            vis_reg[tmr_reg]   <= start_vis;
                            count_reg[tmr_reg] <= start_scaled[COUNT_W-1:0];
                        end
                    end
                    tmr_reg   <= tmr_reg + TMR_W'(1);
                    state_reg <= (tmr_reg == LAST_TMR) ? ST_DONE : ST_SUB;
                end
                ST_DONE:
                begin
                    if (rsp_load)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done step");

    a_irq_implies_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.irq_flags & ~rsp.overflow_mask) == '0))
        else $error("interrupt without overflow");

    a_short_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req_take && req.kind != KIND_ADVANCE) |=> (state_reg == ST_DONE))
        else $error("write or read request did not finish at once");

    a_advance_masks_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_take && req.kind == KIND_ADVANCE) |=> (res_reg.counter_value == '0))
        else $error("advance result carries a counter value");

endmodule

@@ test/cascading_timer_unit_tb.sv @@
// Testbench for cascading_timer_unit: directed and random requests, checked against an
// in-bench timer predictor, with random sender gaps and receiver stalls.
// Depends on ctu_pkg and cascading_timer_unit.
module cascading_timer_unit_tb
    import ctu_pkg::*;
();

    localparam int COUNT_FLOOR  = -(2 ** (COUNT_W - 1));
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 40;
    localparam int FLOOR_ITEMS  = 2052;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_BURSTY} stall_pattern_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    logic [1:0]         tmr_mode    [NUM_TIMERS];
    int                 tmr_count   [NUM_TIMERS];
    int                 tmr_reload  [NUM_TIMERS];
    int                 tmr_shift   [NUM_TIMERS];
    logic               tmr_irq_en  [NUM_TIMERS];
    logic               ctl_waiting [NUM_TIMERS];
    logic [CTL_W-1:0]   ctl_held    [NUM_TIMERS];
    logic [VALUE_W-1:0] tmr_shown   [NUM_TIMERS];

    rsp_t           expected_rsp [$];
    rsp_t           exp_head;
    int             mismatches  = 0;
    int             burst_left  = 0;
    int             idle_cycles = 0;
    int             stall_left  = 0;
    int             stall_tick  = 0;
    stall_pattern_t stall_mode  = STALL_NONE;

    cascading_timer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void clear_timer_model();
        for (int t = 0; t < NUM_TIMERS; t++)
        begin
            tmr_mode[t]    = MODE_INACTIVE;
            tmr_count[t]   = 0;
            tmr_reload[t]  = 32'h10000;
            tmr_shift[t]   = 0;
            tmr_irq_en[t]  = 1'b0;
            ctl_waiting[t] = 1'b0;
            ctl_held[t]    = '0;
            tmr_shown[t]   = '0;
        end
    endfunction

    function automatic int saturate_count(input int v);
        return (v < COUNT_FLOOR) ? COUNT_FLOOR : v;
    endfunction

    function automatic logic [VALUE_W-1:0] shown_count(input int cnt, input int sh);
        int q;
        logic [VALUE_W-1:0] v;
        q = cnt >>> sh;
        v = VALUE_W'(-q);
        return v;
    endfunction

    function automatic int shift_for_select(input logic [1:0] sel);
        int sh;
        case (sel)
            2'd0:    sh = 0;
            2'd1:    sh = 6;
            2'd2:    sh = 8;
            default: sh = 10;
        endcase
        return sh;
    endfunction

    function automatic void apply_held_control(input int t, input logic [CTL_W-1:0] ctl);
        if (ctl[CTL_ENABLE])
        begin
            if (tmr_mode[t] == MODE_INACTIVE)
            begin
                if (ctl[CTL_CASCADE])
                begin
                    tmr_mode[t]  = MODE_CASCADE;
                    tmr_shift[t] = 0;
                end
                else
                begin
                    tmr_mode[t]  = MODE_PRESCALE;
                    tmr_shift[t] = shift_for_select(ctl[1:0]);
                end
                tmr_irq_en[t] = ctl[CTL_IRQ];
                tmr_shown[t]  = shown_count(tmr_reload[t], 0);
                tmr_count[t]  = tmr_reload[t] <<< tmr_shift[t];
            end
        end
        else
            tmr_mode[t] = MODE_INACTIVE;
    endfunction

    function automatic rsp_t predict_response(input req_t r);
        rsp_t res;
        int   idx;
        res = '0;
        idx = int'(r.timer_index);
        if (r.kind == KIND_ADVANCE)
        begin
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                if (tmr_mode[t] != MODE_INACTIVE)
                begin
                    if (tmr_mode[t] != MODE_CASCADE)
                        tmr_count[t] = saturate_count(tmr_count[t] - int'(r.elapsed_cycles));
                    if (tmr_count[t] <= 0)
                    begin
                        res.overflow_mask[t] = 1'b1;
                        if (tmr_irq_en[t])
                            res.irq_flags[t] = 1'b1;
                        if (t + 1 < NUM_TIMERS && tmr_mode[t + 1] == MODE_CASCADE)
                            tmr_count[t + 1] = saturate_count(tmr_count[t + 1] - 1);
                        tmr_count[t] += tmr_reload[t] <<< tmr_shift[t];
                    end
                    tmr_shown[t] = shown_count(tmr_count[t], tmr_shift[t]);
                end
                if (ctl_waiting[t])
                begin
                    apply_held_control(t, ctl_held[t]);
                    ctl_waiting[t] = 1'b0;
                end
            end
        end
        else if (idx < NUM_TIMERS)
        begin
            if (r.kind == KIND_CONTROL)
            begin
                ctl_held[idx]    = r.data_value[CTL_W-1:0];
                ctl_waiting[idx] = 1'b1;
            end
            else if (r.kind == KIND_RELOAD)
                tmr_reload[idx] = 32'h10000 - int'(r.data_value);
            else
                res.counter_value = tmr_shown[idx];
        end
        return res;
    endfunction

    // Called at a rising edge; returns at the edge that accepts the request
    // or after the gap that follows it.
    task automatic send_request(input logic [1:0] kind, input int idx,
                                input int data, input int elapsed);
        req_t r;
        int   gap;
        r.kind           = kind;
        r.timer_index    = idx[1:0];
        r.data_value     = data[VALUE_W-1:0];
        r.elapsed_cycles = elapsed[VALUE_W-1:0];
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        expected_rsp.push_back(predict_response(r));
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic test_idle_reads();
        for (int t = 0; t < NUM_TIMERS; t++)
            send_request(KIND_READ, t, 0, 0);
        send_request(KIND_ADVANCE, 0, 0, 16'hFFFF);
    endtask

    task automatic test_start_and_cascade();
        send_request(KIND_RELOAD, 0, 16'hFFF0, 0);
        send_request(KIND_RELOAD, 1, 16'hFFFE, 0);
        send_request(KIND_RELOAD, 2, 16'h0000, 0);
        send_request(KIND_RELOAD, 3, 16'hFFFF, 0);
        send_request(KIND_CONTROL, 0, 16'h00C0, 0);
        send_request(KIND_CONTROL, 1, 16'hFFC7, 0);
        send_request(KIND_CONTROL, 2, 16'h0083, 0);
        send_request(KIND_CONTROL, 3, 16'h00C1, 0);
        send_request(KIND_ADVANCE, 0, 0, 0);
        send_request(KIND_ADVANCE, 0, 0, 16);
        send_request(KIND_ADVANCE, 0, 0, 16);
        for (int t = 0; t < NUM_TIMERS; t++)
            send_request(KIND_READ, t, 0, 0);
    endtask

    task automatic test_restart_and_disable();
        send_request(KIND_CONTROL, 0, 16'h0080, 0);
        send_request(KIND_CONTROL, 2, 16'h0000, 0);
        send_request(KIND_ADVANCE, 0, 0, 16'hFFFF);
        send_request(KIND_READ, 2, 0, 0);
    endtask

    // Timer 3 with a reload of one loses a full 16-bit step per advance
    // until its count pins at the floor; timer 0 cascades and never moves.
    task automatic test_count_floor();
        send_request(KIND_CONTROL, 0, 16'h0000, 0);
        send_request(KIND_CONTROL, 3, 16'h0000, 0);
        send_request(KIND_ADVANCE, 0, 0, 1);
        send_request(KIND_CONTROL, 0, 16'h0084, 0);
        send_request(KIND_CONTROL, 3, 16'h0080, 0);
        send_request(KIND_ADVANCE, 0, 0, 0);
        for (int n = 0; n < FLOOR_ITEMS; n++)
        begin
            send_request(KIND_ADVANCE, $urandom_range(0, 3), $urandom, 16'hFFFF);
            if (n % 1024 == 1023)
            begin
                send_request(KIND_READ, 3, $urandom, $urandom);
                send_request(KIND_READ, 0, $urandom, $urandom);
            end
        end
        send_request(KIND_READ, 3, $urandom, $urandom);
        send_request(KIND_READ, 0, $urandom, $urandom);
    endtask

    task automatic test_random_traffic();
        int pick;
        int data;
        int elapsed;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick    = $urandom_range(0, 99);
            data    = $urandom;
            elapsed = $urandom;
            if (pick < 45)
            begin
                case ($urandom_range(0, 19))
                    0:       elapsed = 0;
                    1:       elapsed = 16'hFFFF;
                    2, 3, 4: elapsed = $urandom;
                    5, 6, 7, 8, 9, 10: elapsed = $urandom_range(0, 2048);
                    default: elapsed = $urandom_range(0, 64);
                endcase
                send_request(KIND_ADVANCE, $urandom_range(0, 3), data, elapsed);
            end
            else if (pick < 60)
            begin
                data[CTL_ENABLE] = ($urandom_range(0, 3) != 0);
                send_request(KIND_CONTROL, $urandom_range(0, 3), data, elapsed);
            end
            else if (pick < 75)
            begin
                case ($urandom_range(0, 3))
                    0:       data = $urandom;
                    1:       data = $urandom_range(16'hF000, 16'hFFFF);
                    default: data = $urandom_range(16'hFF00, 16'hFFFF);
                endcase
                send_request(KIND_RELOAD, $urandom_range(0, 3), data, elapsed);
            end
            else
                send_request(KIND_READ, $urandom_range(0, 3), data, elapsed);
        end
    endtask

    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_left == 0)
        begin
            stall_mode <= stall_pattern_t'($urandom_range(0, 2));
            stall_left <= $urandom_range(16, 160);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
            default:      rsp_stall <= ((stall_tick % 9) < 5);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: unexpected response %h", $time, rsp);
                mismatches++;
            end
            else
            begin
                exp_head = expected_rsp.pop_front();
                if (rsp.overflow_mask !== exp_head.overflow_mask)
                begin
                    $display("%0t: overflow_mask expected %h actual %h",
                             $time, exp_head.overflow_mask, rsp.overflow_mask);
                    mismatches++;
                end
                if (rsp.irq_flags !== exp_head.irq_flags)
                begin
                    $display("%0t: irq_flags expected %h actual %h",
                             $time, exp_head.irq_flags, rsp.irq_flags);
                    mismatches++;
                end
                if (rsp.counter_value !== exp_head.counter_value)
                begin
                    $display("%0t: counter_value expected %h actual %h",
                             $time, exp_head.counter_value, rsp.counter_value);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no request or response moved for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL cascading_timer_unit");
            $finish;
        end
    end

    initial
    begin
        clear_timer_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_reads();
        test_start_and_cascade();
        test_restart_and_disable();
        test_count_floor();
        test_random_traffic();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("PASS cascading_timer_unit");
        else
            $display("FAIL cascading_timer_unit");
        $finish;
    end

endmodule
